// ===== rtl/core/ppp_pkg.sv =====
// ppp_pkg: shared types, widths and codes of the perspective point projector
// used by every module under rtl/core; depends on nothing
package ppp_pkg;

  localparam int CoordW    = 32;
  localparam int MaxVert   = 256;
  localparam int CntW      = 9;
  localparam int AccW      = 40;
  localparam int CoefW     = 16;
  localparam int RowW      = 48;
  localparam int DvdW      = 48;
  localparam int DvsW      = 32;
  localparam int QuotW     = DvdW + 1;
  localparam int StepW     = 6;
  localparam int QueDepth  = 2;
  localparam int InDataW   = 3 * CoordW;
  localparam int OutDataW  = 6 * CoordW;
  localparam int CfgIdxW   = 3;

  localparam logic [CfgIdxW-1:0] REG_ROT0  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROT1  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROT2  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFX  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFFY  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OFFZ  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd6;

  localparam int ModeNegY  = 0;
  localparam int ModeOrtho = 1;

  typedef struct packed {
    logic               last;
    logic [CoordW-1:0]  z;
    logic [CoordW-1:0]  y;
    logic [CoordW-1:0]  x;
  } item_t;

  typedef struct packed {
    logic   valid;
    item_t  item;
  } qhead_t;

  typedef struct packed {
    logic [2:0][RowW-1:0]   rot;
    logic [2:0][CoordW-1:0] off;
    logic [1:0]             mode;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DvdW-1:0]  dvd;
    logic [DvsW-1:0]  dvs;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QuotW-1:0]  quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/ppp_front.sv =====
// ppp_front: input stream acceptance and a two-entry item queue
// depends on ppp_pkg
module ppp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ppp_pkg::InDataW-1:0]   in_tdata,
  input  logic                          in_tlast,
  output ppp_pkg::qhead_t               head,
  input  logic                          pop
);

  ppp_pkg::item_t mem_r [ppp_pkg::QueDepth];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           do_pop;

  assign in_tready = (cnt_r != 2'(ppp_pkg::QueDepth));
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{last: in_tlast,
                           z: in_tdata[3*ppp_pkg::CoordW-1:2*ppp_pkg::CoordW],
                           y: in_tdata[2*ppp_pkg::CoordW-1:ppp_pkg::CoordW],
                           x: in_tdata[ppp_pkg::CoordW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && do_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== rtl/core/ppp_div.sv =====
// ppp_div: shared restoring divider, one quotient bit per cycle
// depends on ppp_pkg
module ppp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ppp_pkg::div_req_t  req,
  output ppp_pkg::div_rsp_t  rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [ppp_pkg::StepW-1:0]       step_r;
  logic [ppp_pkg::DvdW-1:0]        dvd_r;
  logic [ppp_pkg::DvsW-1:0]        dvs_r;
  logic [ppp_pkg::DvsW-1:0]        rem_r;
  logic                            neg_r;
  logic [ppp_pkg::DvsW:0]          shifted;
  logic                            ge;
  logic [ppp_pkg::DvsW-1:0]        rem_nxt;
  logic [ppp_pkg::DvdW-1:0]        dvd_nxt;
  logic signed [ppp_pkg::QuotW-1:0] mag;

  assign shifted = {rem_r, dvd_r[ppp_pkg::DvdW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign rem_nxt = ge ? ppp_pkg::DvsW'(shifted - {1'b0, dvs_r})
                      : shifted[ppp_pkg::DvsW-1:0];
  assign dvd_nxt = {dvd_r[ppp_pkg::DvdW-2:0], ge};

  assign mag      = $signed({1'b0, dvd_r});
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -mag : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !req.start && busy_r &&
                (step_r == ppp_pkg::StepW'(ppp_pkg::DvdW - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == ppp_pkg::StepW'(ppp_pkg::DvdW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dvd;
      dvs_r <= req.dvs;
      neg_r <= req.neg;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== rtl/core/ppp_back.sv =====
// ppp_back: sequencer for rotation, perspective scale, projection and polygon means
// depends on ppp_pkg; drives the shared divider and the output register
module ppp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppp_pkg::cfg_t                 cfg,
  input  ppp_pkg::qhead_t               head,
  output logic                          pop,
  output ppp_pkg::div_req_t             div_req,
  input  ppp_pkg::div_rsp_t             div_rsp,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ppp_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_ROT  = 11'b00000000010,
    S_DVS  = 11'b00000000100,
    S_DVW  = 11'b00000001000,
    S_PROJ = 11'b00000010000,
    S_ACC  = 11'b00000100000,
    S_MDS  = 11'b00001000000,
    S_MDW  = 11'b00010000000,
    S_MSS  = 11'b00100000000,
    S_MSW  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  localparam int CW = ppp_pkg::CoordW;
  localparam logic signed [CW-1:0] SMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SMin = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] One  = CW'(65536);

  function automatic logic signed [CW-1:0] sat_c(input logic signed [65:0] v);
    if (v > 66'(SMax)) return SMax;
    if (v < 66'(SMin)) return SMin;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [ppp_pkg::AccW-1:0] sat_a(
      input logic signed [ppp_pkg::AccW:0] v);
    if (v[ppp_pkg::AccW] != v[ppp_pkg::AccW-1])
      return {v[ppp_pkg::AccW], {(ppp_pkg::AccW-1){~v[ppp_pkg::AccW]}}};
    return v[ppp_pkg::AccW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] finish_row(input logic signed [49:0] s,
                                                      input logic signed [CW-1:0] o);
    logic signed [49:0] t;
    logic signed [50:0] d;
    t = (s + 50'sd8192) >>> 14;
    d = 51'(t) - 51'(o);
    return sat_c(66'(d));
  endfunction

  function automatic logic signed [CW-1:0] round_prod(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = (65'(p) + 65'sd32768) >>> 16;
    return sat_c(66'(t));
  endfunction

  state_t                            state_r;
  ppp_pkg::item_t                    item_r;
  logic signed [CW-1:0]              v_r [3];
  logic [1:0]                        mrow_r, mcol_r, arow_r, acol_r;
  logic                              issue_r, prod_vld_r;
  logic signed [47:0]                rprod_r;
  logic signed [49:0]                racc_r;
  logic signed [49:0]                rsum;
  logic signed [CW-1:0]              row_val;
  logic signed [CW-1:0]              neg_y;
  logic signed [ppp_pkg::CoefW-1:0]  coef;
  logic signed [CW-1:0]              pt;
  logic signed [CW-1:0]              scale_r;
  logic                              zflag_r;
  logic signed [63:0]                pprod_r;
  logic [1:0]                        pstep_r;
  logic signed [ppp_pkg::AccW-1:0]   dacc_r, sacc_r;
  logic [ppp_pkg::CntW-1:0]          cnt_r;
  logic signed [CW-1:0]              mean_d_r, mean_s_r;
  ppp_pkg::div_req_t                 req_r;
  logic                              out_valid_r;
  logic [ppp_pkg::OutDataW-1:0]      out_data_r;
  logic                              out_last_r, out_user_r;
  logic signed [CW:0]                num;
  logic [CW:0]                       num_mag;
  logic [CW-1:0]                     dep_mag;
  logic signed [ppp_pkg::AccW:0]     acc_x;
  logic [ppp_pkg::AccW:0]            acc_mag;

  assign coef = $signed(cfg.rot[mrow_r][{mcol_r, 4'b0000} +: ppp_pkg::CoefW]);
  assign pt   = (mcol_r == 2'd0) ? $signed(item_r.x) :
                (mcol_r == 2'd1) ? $signed(item_r.y) : $signed(item_r.z);
  assign rsum = ((acol_r == 2'd0) ? 50'sd0 : racc_r) + 50'(rprod_r);
  assign row_val = finish_row(rsum, $signed(cfg.off[arow_r]));
  assign neg_y = (v_r[1] == SMin) ? SMax : -v_r[1];

  assign num     = -$signed({cfg.off[2][CW-1], cfg.off[2]});
  assign num_mag = num[CW] ? (CW+1)'(-num) : num;
  assign dep_mag = v_r[2][CW-1] ? CW'(-v_r[2]) : v_r[2];
  assign acc_x   = (state_r == S_MDS) ? (ppp_pkg::AccW+1)'(dacc_r)
                                      : (ppp_pkg::AccW+1)'(sacc_r);
  assign acc_mag = acc_x[ppp_pkg::AccW] ? (ppp_pkg::AccW+1)'(-acc_x) : acc_x;

  assign pop        = (state_r == S_IDLE) && head.valid;
  assign div_req    = req_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      req_r.start <= 1'b0;
      dacc_r      <= '0;
      sacc_r      <= '0;
      cnt_r       <= '0;
    end else begin
      req_r.start <= (state_r == S_DVS) || (state_r == S_MDS) || (state_r == S_MSS);
      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            item_r     <= head.item;
            mrow_r     <= 2'd0;
            mcol_r     <= 2'd0;
            issue_r    <= 1'b1;
            prod_vld_r <= 1'b0;
            mean_d_r   <= '0;
            mean_s_r   <= '0;
            zflag_r    <= 1'b0;
            state_r    <= S_ROT;
          end
        end
        S_ROT: begin
          prod_vld_r <= issue_r;
          if (issue_r) begin
            rprod_r <= coef * pt;
            arow_r  <= mrow_r;
            acol_r  <= mcol_r;
            if (mcol_r == 2'd2) begin
              mcol_r <= 2'd0;
              mrow_r <= mrow_r + 2'd1;
              if (mrow_r == 2'd2) issue_r <= 1'b0;
            end else begin
              mcol_r <= mcol_r + 2'd1;
            end
          end
          if (prod_vld_r) begin
            racc_r <= rsum;
            if (acol_r == 2'd2) begin
              v_r[arow_r] <= row_val;
              if (arow_r == 2'd2) begin
                if (cfg.mode[ppp_pkg::ModeNegY]) v_r[1] <= neg_y;
                pstep_r <= 2'd0;
                if (cfg.mode[ppp_pkg::ModeOrtho]) begin
                  scale_r <= One;
                  state_r <= S_ACC;
                end else if (row_val == '0) begin
                  zflag_r <= 1'b1;
                  scale_r <= (num > 0) ? SMax : ((num < 0) ? SMin : '0);
                  state_r <= S_PROJ;
                end else begin
                  state_r <= S_DVS;
                end
              end
            end
          end
        end
        S_DVS: begin
          req_r.dvd   <= {num_mag[ppp_pkg::DvdW-17:0], 16'h0000};
          req_r.dvs   <= dep_mag;
          req_r.neg   <= num[CW] ^ v_r[2][CW-1];
          state_r     <= S_DVW;
        end
        S_DVW: begin
          if (div_rsp.done) begin
            scale_r <= sat_c(66'(div_rsp.quot));
            state_r <= S_PROJ;
          end
        end
        S_PROJ: begin
          pstep_r <= pstep_r + 2'd1;
          case (pstep_r)
            2'd0: pprod_r <= v_r[0] * scale_r;
            2'd1: begin
              v_r[0]  <= round_prod(pprod_r);
              pprod_r <= v_r[1] * scale_r;
            end
            default: begin
              v_r[1]  <= round_prod(pprod_r);
              state_r <= S_ACC;
            end
          endcase
        end
        S_ACC: begin
          if (cnt_r < ppp_pkg::CntW'(ppp_pkg::MaxVert)) begin
            dacc_r <= sat_a((ppp_pkg::AccW+1)'(dacc_r) + (ppp_pkg::AccW+1)'(v_r[2]));
            sacc_r <= sat_a((ppp_pkg::AccW+1)'(sacc_r) + (ppp_pkg::AccW+1)'(scale_r));
            cnt_r  <= cnt_r + 1'b1;
          end
          state_r <= item_r.last ? S_MDS : S_OUT;
        end
        S_MDS, S_MSS: begin
          req_r.dvd   <= ppp_pkg::DvdW'(acc_mag);
          req_r.dvs   <= ppp_pkg::DvsW'(cnt_r);
          req_r.neg   <= acc_x[ppp_pkg::AccW];
          state_r     <= (state_r == S_MDS) ? S_MDW : S_MSW;
        end
        S_MDW: begin
          if (div_rsp.done) begin
            mean_d_r <= div_rsp.quot[CW-1:0];
            state_r  <= S_MSS;
          end
        end
        S_MSW: begin
          if (div_rsp.done) begin
            mean_s_r <= div_rsp.quot[CW-1:0];
            dacc_r   <= '0;
            sacc_r   <= '0;
            cnt_r    <= '0;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {mean_s_r, mean_d_r, scale_r, v_r[2], v_r[1], v_r[0]};
            out_last_r  <= item_r.last;
            out_user_r  <= zflag_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/perspective_point_projector.sv =====
// sequence: rotation, then in perspective mode a scale division on the 48-step
// shared divider (none on zero depth) and projection; a vertex marked last adds
// the two mean divisions; one vertex in flight in the back end, the next starts
// once it is handed to the output register; a two-entry queue accepts ahead
// reset: synchronous active-low rst_n restores identity matrix, zero offsets and
// mode, clears the sums, the count, the queue and the output valid
module perspective_point_projector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ppp_pkg::InDataW-1:0]         in_tdata,   // point_x, point_y, point_z
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // screen_x, screen_y, view_depth, view_scale, mean_depth, mean_scale
  output logic [ppp_pkg::OutDataW-1:0]        out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser,  // depth_zero_flag
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppp_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ppp_pkg::RowW-1:0]            cfg_data
);

  ppp_pkg::cfg_t      cfg_r;
  ppp_pkg::qhead_t    head;
  logic               pop;
  ppp_pkg::div_req_t  div_req;
  ppp_pkg::div_rsp_t  div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot[0] <= ppp_pkg::RowW'(16384);
      cfg_r.rot[1] <= ppp_pkg::RowW'(16384) << 16;
      cfg_r.rot[2] <= ppp_pkg::RowW'(16384) << 32;
      cfg_r.off    <= '0;
      cfg_r.mode   <= 2'b00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppp_pkg::REG_ROT0: cfg_r.rot[0] <= cfg_data;
        ppp_pkg::REG_ROT1: cfg_r.rot[1] <= cfg_data;
        ppp_pkg::REG_ROT2: cfg_r.rot[2] <= cfg_data;
        ppp_pkg::REG_OFFX: cfg_r.off[0] <= cfg_data[ppp_pkg::CoordW-1:0];
        ppp_pkg::REG_OFFY: cfg_r.off[1] <= cfg_data[ppp_pkg::CoordW-1:0];
        ppp_pkg::REG_OFFZ: cfg_r.off[2] <= cfg_data[ppp_pkg::CoordW-1:0];
        ppp_pkg::REG_MODE: cfg_r.mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .head      (head),
    .pop       (pop)
  );

  ppp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ppp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/ppp_checker.sv =====
// ppp_checker: port-level assertions on the projector's result stream
// depends on ppp_pkg; bound to perspective_point_projector
module ppp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ppp_pkg::OutDataW-1:0]   out_tdata,
  input logic                           out_tlast,
  input logic                           out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[95:64] == 32'd0)
    else $error("zero-depth flag with non-zero depth");

  a_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[191:128] == 64'd0)
    else $error("means non-zero outside the last vertex");

endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== dv/perspective_point_projector_test.sv =====
// perspective_point_projector_test: self-checking bench for the vertex projector
// drives a directed table then random polygons, predicts every transaction in-bench
// depends on ppp_pkg and perspective_point_projector
module perspective_point_projector_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ppp_pkg::InDataW-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ppp_pkg::OutDataW-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ppp_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [ppp_pkg::RowW-1:0] cfg_data = '0;

  typedef struct {
    logic signed [31:0] sx, sy, depth, scale, mdepth, mscale;
    logic mvalid, zflag;
  } proj_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic lst;
    logic chk;
    logic signed [31:0] want_depth, want_scale;
  } vec_t;

  proj_t expected_q[$];
  logic [ppp_pkg::RowW-1:0] rot_m[3];
  logic signed [31:0] off_m[3];
  logic [1:0] mode_m;
  longint depth_sum, scale_sum;
  int vcount;
  int errors = 0;
  longint cycles = 0;
  bit quiet_out = 1'b0;
  bit quiet_in = 1'b0;

  perspective_point_projector u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4000000) begin
      $display("[perspective_point_projector] ERROR");
      $finish;
    end
  end

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic proj_t project_vertex(logic signed [31:0] px, logic signed [31:0] py,
                                           logic signed [31:0] pz, logic lst);
    proj_t r;
    longint p[3], v[3], acc, num, sc;
    logic signed [15:0] c;
    p[0] = px; p[1] = py; p[2] = pz;
    r.zflag = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        c = rot_m[i][16*j +: 16];
        acc += longint'(c) * p[j];
      end
      v[i] = clamp(((acc + 8192) >>> 14) - longint'(off_m[i]), 32);
    end
    if (mode_m[ppp_pkg::ModeNegY]) v[1] = clamp(-v[1], 32);
    if (mode_m[ppp_pkg::ModeOrtho]) sc = 65536;
    else begin
      num = -longint'(off_m[2]);
      if (v[2] == 0) begin
        r.zflag = 1'b1;
        sc = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
      end else sc = clamp((num * 65536) / v[2], 32);
      v[0] = clamp((v[0] * sc + 32768) >>> 16, 32);
      v[1] = clamp((v[1] * sc + 32768) >>> 16, 32);
    end
    if (vcount < ppp_pkg::MaxVert) begin
      depth_sum = clamp(depth_sum + v[2], 40);
      scale_sum = clamp(scale_sum + sc, 40);
      vcount++;
    end
    r.mdepth = 0; r.mscale = 0;
    if (lst) begin
      r.mdepth = depth_sum / vcount;
      r.mscale = scale_sum / vcount;
      depth_sum = 0; scale_sum = 0; vcount = 0;
    end
    r.sx = v[0]; r.sy = v[1]; r.depth = v[2]; r.scale = sc; r.mvalid = lst;
    return r;
  endfunction

  task automatic write_reg(logic [ppp_pkg::CfgIdxW-1:0] idx, logic [ppp_pkg::RowW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      ppp_pkg::REG_ROT0, ppp_pkg::REG_ROT1, ppp_pkg::REG_ROT2: rot_m[idx] = val;
      ppp_pkg::REG_OFFX, ppp_pkg::REG_OFFY, ppp_pkg::REG_OFFZ:
        off_m[idx - ppp_pkg::REG_OFFX] = val[31:0];
      ppp_pkg::REG_MODE: mode_m = val[1:0];
      default: ;
    endcase
  endtask

  task automatic send_vertex(vec_t t);
    proj_t e;
    if (!quiet_in)
      while ($urandom_range(99) < 14) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    e = project_vertex(t.x, t.y, t.z, t.lst);
    if (t.chk && (e.depth !== t.want_depth || e.scale !== t.want_scale)) begin
      $error("table row mismatch with prediction");
      errors++;
    end
    expected_q = {expected_q, e};
    in_tvalid <= 1'b1;
    in_tdata <= {t.z, t.y, t.x};
    in_tlast <= t.lst;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic chk(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    proj_t e;
    if (rst_n) out_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 14);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        chk("screen_x", e.sx, out_tdata[31:0]);
        chk("screen_y", e.sy, out_tdata[63:32]);
        chk("view_depth", e.depth, out_tdata[95:64]);
        chk("view_scale", e.scale, out_tdata[127:96]);
        chk("mean_depth", e.mdepth, out_tdata[159:128]);
        chk("mean_scale", e.mscale, out_tdata[191:160]);
        chk("mean_valid", e.mvalid, out_tlast);
        chk("depth_zero_flag", e.zflag, out_tuser);
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 8) - 4;
      3: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ppp_pkg::RowW-1:0] rand_row();
    logic [ppp_pkg::RowW-1:0] r;
    for (int j = 0; j < 3; j++)
      r[16*j +: 16] = $urandom_range(3) == 0 ? 16'($urandom) :
                      16'($signed($urandom_range(0, 32768)) - 16384);
    return r;
  endfunction

  task automatic random_config(int sel);
    logic signed [31:0] offz;
    for (int i = 0; i < 3; i++)
      write_reg(ppp_pkg::CfgIdxW'(ppp_pkg::REG_ROT0 + i),
                sel == 0 ? {ppp_pkg::RowW{1'b1}} : rand_row());
    write_reg(ppp_pkg::REG_OFFX, sel == 0 ? 48'h7fffffff : 48'($unsigned(rand_coord())));
    write_reg(ppp_pkg::REG_OFFY, sel == 0 ? 48'h80000000 : 48'($unsigned(rand_coord())));
    offz = sel == 0 ? 32'sh80000000 : ($urandom_range(1) ? rand_coord() : -32'sd655360);
    write_reg(ppp_pkg::REG_OFFZ, 48'($unsigned(offz)));
    write_reg(ppp_pkg::REG_MODE, 48'($urandom_range(3)));
  endtask

  vec_t dir_tab[] = '{
    '{0, 0, 0, 1, 1, 0, 0},
    '{32'sh10000, 32'sh20000, 32'sh30000, 0, 1, 32'sh30000, 0},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 1, 32'sh7fffffff, 0},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 1, 32'sh80000000, 0},
    '{5, -5, 1, 1, 0, 0, 0}
  };

  initial begin
    vec_t t;
    int items, plen;
    rot_m[0] = 48'd16384; rot_m[1] = 48'd16384 << 16; rot_m[2] = 48'd16384 << 32;
    off_m = '{0, 0, 0};
    mode_m = 2'b00;
    depth_sum = 0; scale_sum = 0; vcount = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_vertex(dir_tab[i]);
    drain_results();
    write_reg(ppp_pkg::REG_OFFZ, 48'hfff6_0000);
    write_reg(ppp_pkg::REG_MODE, 48'd1);
    foreach (dir_tab[i]) begin
      t = dir_tab[i]; t.chk = 1'b0; send_vertex(t);
    end
    t = '{1, 1, 1, 0, 0, 0, 0};
    for (int i = 0; i < ppp_pkg::MaxVert + 3; i++) begin
      t.lst = (i == ppp_pkg::MaxVert + 2);
      send_vertex(t);
    end
    drain_results();
    write_reg(ppp_pkg::REG_MODE, 48'd2);
    foreach (dir_tab[i]) begin
      t = dir_tab[i]; t.chk = 1'b0; send_vertex(t);
    end
    drain_results();
    random_config(0);
    for (int i = 0; i < 8; i++) begin
      t = '{rand_coord(), rand_coord(), rand_coord(), i[0], 0, 0, 0};
      send_vertex(t);
    end
    drain_results();
    items = 0;
    for (int ph = 0; items < 1460; ph++) begin
      quiet_in = (ph == 3); quiet_out = (ph == 3);
      random_config(1);
      for (int k = 0; k < 30; k++) begin
        plen = $urandom_range(1, 8);
        for (int v = 0; v < plen; v++) begin
          t.x = rand_coord(); t.y = rand_coord(); t.z = rand_coord();
          t.lst = (v == plen - 1) ? ($urandom_range(9) != 0) : 1'b0;
          t.chk = 1'b0;
          send_vertex(t);
          items++;
        end
      end
      drain_results();
    end
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[perspective_point_projector] OK");
    else $display("[perspective_point_projector] ERROR");
    $finish;
  end
endmodule
